// ===== rtl/icfm_pkg.sv =====
// ----------------------------------------------------------------------------
// icfm_pkg
// Shared widths, reset values, register indexes and the command and status
// bundles between the controller and the datapath of the frequency meter.
// ----------------------------------------------------------------------------
`default_nettype none

package icfm_pkg;

  // field widths
  localparam int unsigned CapW    = 16;
  localparam int unsigned ReloadW = 16;
  localparam int unsigned PrescW  = 16;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned ClockW  = 28;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned FreqW   = 31;
  localparam int unsigned ProdW   = PeriodW + ReloadW + 1;

  // apb port
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 4;

  // register reset values
  localparam logic [ReloadW-1:0] ReloadRst = 16'hFFFF;
  localparam logic [PrescW-1:0]  PrescRst  = 16'd71;
  localparam logic [CodeW-1:0]   CodeRst   = 2'd0;
  localparam logic [ClockW-1:0]  ClockRst  = 28'd72000000;

  // divider: dividend is the clock width, divisor is the period width
  localparam int unsigned DivSteps = ClockW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // event kinds
  localparam logic CmdTick = 1'b0;
  localparam logic CmdEdge = 1'b1;

  // register indexes
  typedef enum logic [1:0] {
    REG_RELOAD = 2'd0,
    REG_PRESC  = 2'd1,
    REG_CODE   = 2'd2,
    REG_CLOCK  = 2'd3
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // input transfer this cycle
    logic mul;        // register overflow count times reload plus one
    logic sum;        // add capture, saturate, store period
    logic div_start;  // launch the shared divider
    logic div_sel;    // 0: clock / (prescaler+1), 1: first quotient / period
    logic freq_load;  // store the frequency
    logic emit;       // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phase;        // measurement running
    logic div_done;     // divider finished this cycle
    logic period_zero;  // stored period is zero
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/icfm_if.sv =====
// ----------------------------------------------------------------------------
// icfm channel interfaces
// Valid/ready channels for timer events in and measurement results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface icfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [icfm_pkg::CapW-1:0]   capture_value;

  modport source (output valid, output command, output capture_value, input ready);
  modport sink   (input valid, input command, input capture_value, output ready);
endinterface

interface icfm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         measuring;
  logic [icfm_pkg::PeriodW-1:0] period_count;
  logic [icfm_pkg::FreqW-1:0]   frequency_hz;
  logic                         new_result;
  logic                         error_flag;

  modport source (output valid, output measuring, output period_count,
                  output frequency_hz, output new_result, output error_flag,
                  input ready);
  modport sink   (input valid, input measuring, input period_count,
                  input frequency_hz, input new_result, input error_flag,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/icfm_div.sv =====
// ----------------------------------------------------------------------------
// icfm_div
// Restoring divider, one quotient bit per cycle. Quotient is held after the
// run; done pulses for one cycle when it becomes valid.
// ----------------------------------------------------------------------------
`default_nettype none

module icfm_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [icfm_pkg::ClockW-1:0]  dividend,
  input  wire logic [icfm_pkg::PeriodW-1:0] divisor,
  output logic                              busy,
  output logic                              done,
  output logic [icfm_pkg::ClockW-1:0]       quotient
);

  logic [icfm_pkg::DivCntW-1:0] cnt;
  logic [icfm_pkg::PeriodW-1:0] rem;
  logic [icfm_pkg::PeriodW-1:0] dvs;
  logic [icfm_pkg::PeriodW:0]   trial;
  logic [icfm_pkg::PeriodW:0]   diff;
  logic                         ge;

  // one trial subtraction
  always_comb begin
    trial = {rem, quotient[icfm_pkg::ClockW-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == icfm_pkg::DivCntW'(icfm_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[icfm_pkg::PeriodW-1:0] : trial[icfm_pkg::PeriodW-1:0];
      quotient <= {quotient[icfm_pkg::ClockW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/icfm_dp.sv =====
// ----------------------------------------------------------------------------
// icfm_dp
// Datapath: configuration registers, measurement state, period multiply and
// saturate, frequency division through the shared divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icfm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire icfm_pkg::cmd_t               cmd,
  output icfm_pkg::sts_t                    sts,
  // input payload
  input  wire logic                         in_command,
  input  wire logic [icfm_pkg::CapW-1:0]    in_capture_value,
  // output payload
  output logic                              out_measuring,
  output logic [icfm_pkg::PeriodW-1:0]      out_period_count,
  output logic [icfm_pkg::FreqW-1:0]        out_frequency_hz,
  output logic                              out_new_result,
  output logic                              out_error_flag,
  // apb
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [icfm_pkg::AddrW-1:0]   paddr,
  input  wire logic [icfm_pkg::DataW-1:0]   pwdata,
  output logic [icfm_pkg::DataW-1:0]        prdata
);

  logic [icfm_pkg::ReloadW-1:0] reload_value;
  logic [icfm_pkg::PrescW-1:0]  timer_prescaler;
  logic [icfm_pkg::CodeW-1:0]   capture_divider_code;
  logic [icfm_pkg::ClockW-1:0]  clock_hz;

  logic                         phase;
  logic [icfm_pkg::PeriodW-1:0] overflow_count;
  logic [icfm_pkg::PeriodW-1:0] period_store;
  logic [icfm_pkg::FreqW-1:0]   frequency_store;
  logic [icfm_pkg::CapW-1:0]    cap_hold;
  logic [icfm_pkg::ProdW-1:0]   product;
  logic                         done_flag;
  logic                         err_flag;

  logic [icfm_pkg::ReloadW:0]   reload_p1;
  logic [icfm_pkg::PrescW:0]    presc_p1;
  logic [icfm_pkg::ProdW:0]     sum;
  logic                         sat;
  logic [icfm_pkg::ClockW-1:0]  div_dividend;
  logic [icfm_pkg::PeriodW-1:0] div_divisor;
  logic                         div_busy;
  logic                         div_done;
  logic [icfm_pkg::ClockW-1:0]  div_quotient;
  logic [icfm_pkg::FreqW-1:0]   freq_scaled;
  icfm_pkg::reg_idx_t           reg_sel;
  logic                         wr_en;

  assign reg_sel = icfm_pkg::reg_idx_t'(paddr[icfm_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value         <= icfm_pkg::ReloadRst;
      timer_prescaler      <= icfm_pkg::PrescRst;
      capture_divider_code <= icfm_pkg::CodeRst;
      clock_hz             <= icfm_pkg::ClockRst;
    end else if (wr_en) begin
      case (reg_sel)
        icfm_pkg::REG_RELOAD: reload_value         <= pwdata[icfm_pkg::ReloadW-1:0];
        icfm_pkg::REG_PRESC:  timer_prescaler      <= pwdata[icfm_pkg::PrescW-1:0];
        icfm_pkg::REG_CODE:   capture_divider_code <= pwdata[icfm_pkg::CodeW-1:0];
        icfm_pkg::REG_CLOCK:  clock_hz             <= pwdata[icfm_pkg::ClockW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      icfm_pkg::REG_RELOAD: prdata = icfm_pkg::DataW'(reload_value);
      icfm_pkg::REG_PRESC:  prdata = icfm_pkg::DataW'(timer_prescaler);
      icfm_pkg::REG_CODE:   prdata = icfm_pkg::DataW'(capture_divider_code);
      icfm_pkg::REG_CLOCK:  prdata = icfm_pkg::DataW'(clock_hz);
      default:              prdata = '0;
    endcase
  end

  // period arithmetic
  always_comb begin
    reload_p1 = {1'b0, reload_value} + 1'b1;
    presc_p1  = {1'b0, timer_prescaler} + 1'b1;
    sum       = {1'b0, product} + (icfm_pkg::ProdW + 1)'(cap_hold);
    sat       = |sum[icfm_pkg::ProdW:icfm_pkg::PeriodW];
  end

  // divider operands: first clock / (prescaler+1), then that / period
  always_comb begin
    if (cmd.div_sel) begin
      div_dividend = div_quotient;
      div_divisor  = period_store;
    end else begin
      div_dividend = clock_hz;
      div_divisor  = icfm_pkg::PeriodW'(presc_p1);
    end
    freq_scaled = {{(icfm_pkg::FreqW - icfm_pkg::ClockW){1'b0}}, div_quotient}
                  << capture_divider_code;
  end

  icfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= 1'b0;
      overflow_count  <= '0;
      period_store    <= '0;
      frequency_store <= '0;
      done_flag       <= 1'b0;
      err_flag        <= 1'b0;
    end else begin
      if (cmd.take) begin
        done_flag <= 1'b0;
        err_flag  <= 1'b0;
        if (in_command == icfm_pkg::CmdEdge) begin
          phase <= ~phase;
          if (!phase) begin
            overflow_count <= '0;
          end
        end else if (phase && !(&overflow_count)) begin
          overflow_count <= overflow_count + 1'b1;
        end
      end
      if (cmd.sum) begin
        done_flag    <= 1'b1;
        period_store <= sat ? '1 : sum[icfm_pkg::PeriodW-1:0];
        err_flag     <= sat || (sum[icfm_pkg::PeriodW-1:0] == '0);
      end
      if (cmd.freq_load) begin
        frequency_store <= (period_store == '0) ? '0 : freq_scaled;
      end
    end
  end

  // capture hold and product
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cap_hold <= in_capture_value;
    end
    if (cmd.mul) begin
      product <= icfm_pkg::ProdW'(overflow_count) * icfm_pkg::ProdW'(reload_p1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_measuring    <= phase;
      out_period_count <= period_store;
      out_frequency_hz <= frequency_store;
      out_new_result   <= done_flag;
      out_error_flag   <= err_flag;
    end
  end

  assign sts.phase       = phase;
  assign sts.div_done    = div_done;
  assign sts.period_zero = (period_store == '0);

  // divider is never relaunched mid-run
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider launched while busy");

  // a completed measurement with no error has a nonzero period
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.sum |=> (err_flag || period_store != '0))
    else $error("zero period without error flag");

  // overflow count only moves on an input transfer (a tick while measuring or a first edge)
  a_ovf_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd.take |=> $stable(overflow_count))
    else $error("overflow count changed without an input transfer");

endmodule

`default_nettype wire

// ===== rtl/icfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// icfm_ctrl
// Controller: accepts one event at a time, sequences the period and, unless the
// period is zero, the two divisions for a closing edge, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icfm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_command,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire icfm_pkg::sts_t sts,
  output icfm_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_CHK,
    S_DIV1,
    S_DIV2,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_command == icfm_pkg::CmdEdge && sts.phase) begin
            state_next = S_MUL;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.period_zero) begin
          cmd.freq_load = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.freq_load = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register is never overwritten while its result is still held
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result overwritten before transfer");

  // an emitted result is offered on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not offered");

  // a closing edge always goes through the period multiply
  a_second_edge: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && in_command == icfm_pkg::CmdEdge && sts.phase) |=> state == S_MUL)
    else $error("second edge skipped the period computation");

endmodule

`default_nettype wire

// ===== rtl/input_capture_frequency_meter_top.sv =====
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_top
// Input capture period and frequency meter: overflow ticks and capture edges
// in, one status/result item out per event, APB register port.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    command, capture_value
//   out_ch   out  valid/ready    measuring, period_count, frequency_hz,
//                                new_result, error_flag
//   apb      in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// An overflow tick or a first edge goes from its transfer through the emit state
// into the output register. A closing edge goes through the period multiply,
// saturation and zero check, then, unless the period is zero, two runs of the
// one shared bit-serial divider (launch plus 28 steps each), then the load.
// One event is in flight at a time; a finished result waits in the output
// register while the next event is taken in, and a result that cannot leave
// holds the controller, which stalls the input.
// Synchronous active-high reset clears state and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module input_capture_frequency_meter_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  icfm_in_if.sink                         in_ch,
  icfm_out_if.source                      out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [icfm_pkg::AddrW-1:0] paddr,
  input  wire logic [icfm_pkg::DataW-1:0] pwdata,
  output logic [icfm_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  icfm_pkg::cmd_t cmd;
  icfm_pkg::sts_t sts;

  assign pready = 1'b1;

  // controller
  icfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath
  icfm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_capture_value (in_ch.capture_value),
    .out_measuring    (out_ch.measuring),
    .out_period_count (out_ch.period_count),
    .out_frequency_hz (out_ch.frequency_hz),
    .out_new_result   (out_ch.new_result),
    .out_error_flag   (out_ch.error_flag),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
  );

endmodule

`default_nettype wire

// ===== sim/icfm_meter_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icfm_meter_check
// Watches the event and result channels and the register port of the
// frequency meter. It keeps its own copy of the meter state and registers,
// predicts one status item for every event transfer, and compares each
// result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module icfm_meter_check
  import icfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  icfm_in_if                in_ch,
  icfm_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output int unsigned       errors,
  output int unsigned       pending
);

  typedef struct packed {
    logic               measuring;
    logic [PeriodW-1:0] period_count;
    logic [FreqW-1:0]   frequency_hz;
    logic               new_result;
    logic               error_flag;
  } meter_result_t;

  // predicted status items, oldest first
  meter_result_t status_q[$];
  int unsigned   fail_count = 0;

  // register copies
  logic [ReloadW-1:0] reload_q;
  logic [PrescW-1:0]  presc_q;
  logic [CodeW-1:0]   code_q;
  logic [ClockW-1:0]  clock_q;

  // meter state copies
  logic               running_q;
  logic [PeriodW-1:0] ovf_q;
  logic [PeriodW-1:0] period_q;
  logic [FreqW-1:0]   freq_q;

  // clock / (prescaler+1) / period, scaled by the edges per capture
  function automatic logic [FreqW-1:0] freq_from_period(input logic [PeriodW-1:0] counts);
    logic [63:0] scaled;
    if (counts == '0) return '0;
    scaled = 64'(clock_q) / (64'(presc_q) + 64'd1);
    scaled = scaled / 64'(counts);
    scaled = scaled << code_q;
    if (scaled > 64'h7FFF_FFFF) scaled = 64'h7FFF_FFFF;
    return scaled[FreqW-1:0];
  endfunction

  // one event in, one status item predicted
  task automatic predict_status(input logic cmd, input logic [CapW-1:0] cap);
    meter_result_t r;
    logic [63:0]   span;
    r = '0;
    if (cmd == CmdTick) begin
      // ticks only count while a measurement runs, saturating
      if (running_q && ovf_q != '1) ovf_q = ovf_q + 1'b1;
    end else if (!running_q) begin
      ovf_q     = '0;
      running_q = 1'b1;
    end else begin
      span = 64'(ovf_q) * (64'(reload_q) + 64'd1) + 64'(cap);
      if (span > 64'hFFFF_FFFF) begin
        span         = 64'hFFFF_FFFF;
        r.error_flag = 1'b1;
      end
      period_q = span[PeriodW-1:0];
      if (period_q == '0) r.error_flag = 1'b1;
      freq_q       = freq_from_period(period_q);
      running_q    = 1'b0;
      r.new_result = 1'b1;
    end
    r.measuring    = running_q;
    r.period_count = period_q;
    r.frequency_hz = freq_q;
    status_q.push_back(r);
  endtask

  function automatic int unsigned field_diff(input string name, input logic [31:0] want,
                                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic compare_status(input meter_result_t got);
    meter_result_t want;
    int unsigned   bad;
    if (status_q.size() == 0) begin
      $display("%0t result with no event waiting: expected none actual %h", $time, got);
      fail_count++;
      return;
    end
    want = status_q.pop_front();
    bad  = field_diff("measuring", 32'(want.measuring), 32'(got.measuring));
    bad += field_diff("period_count", want.period_count, got.period_count);
    bad += field_diff("frequency_hz", 32'(want.frequency_hz), 32'(got.frequency_hz));
    bad += field_diff("new_result", 32'(want.new_result), 32'(got.new_result));
    bad += field_diff("error_flag", 32'(want.error_flag), 32'(got.error_flag));
    if (bad != 0) fail_count++;
  endtask

  // result transfers first: they are always older than a same-edge event
  always @(posedge clk) begin
    if (rst) begin
      reload_q  = ReloadRst;
      presc_q   = PrescRst;
      code_q    = CodeRst;
      clock_q   = ClockRst;
      running_q = 1'b0;
      ovf_q     = '0;
      period_q  = '0;
      freq_q    = '0;
      status_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready)
        compare_status('{measuring:    out_ch.measuring,
                         period_count: out_ch.period_count,
                         frequency_hz: out_ch.frequency_hz,
                         new_result:   out_ch.new_result,
                         error_flag:   out_ch.error_flag});
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          REG_RELOAD: reload_q = pwdata[ReloadW-1:0];
          REG_PRESC:  presc_q  = pwdata[PrescW-1:0];
          REG_CODE:   code_q   = pwdata[CodeW-1:0];
          REG_CLOCK:  clock_q  = pwdata[ClockW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_status(in_ch.command, in_ch.capture_value);
    end
    errors  <= fail_count;
    pending <= status_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the input capture frequency meter: directed edge and tick
// sequences at register extremes, then random measurements with noise over
// several register settings and a long result hold-off. The checker beside
// the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import icfm_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned RandomItems = 1800;
  localparam int unsigned Phases      = 6;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned DrainCycles = 80;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  int unsigned       errors;
  int unsigned       pending;
  int unsigned       cycles = 0;

  // stimulus control shared with the result side
  bit                hold_off_req  = 1'b0;
  bit                hold_off_done = 1'b0;
  bit                offering      = 1'b0;
  int unsigned       burst_left    = 0;
  int unsigned       items_sent    = 0;

  icfm_in_if  in_ch ();
  icfm_out_if out_ch ();

  input_capture_frequency_meter_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  icfm_meter_check meter_check (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("input_capture_frequency_meter_top: mismatch");
      $finish;
    end
  end

  // result side: random ready rates and one long hold-off
  initial begin
    int unsigned ready_pct;
    int unsigned rate_left;
    int unsigned held;
    ready_pct = 100;
    rate_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (rate_left == 0) begin
        rate_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          2:       ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      rate_left--;
      out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // offer one event, with a gap between bursts, and wait for its transfer
  task automatic push_event(input logic cmd, input logic [CapW-1:0] cap);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (offering) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.capture_value <= cap;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic drain();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
  endtask

  // setup and access cycle; the caller releases the bus after the last one
  task automatic apb_write(input reg_idx_t idx, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_meter(input logic [DataW-1:0] reload, input logic [DataW-1:0] presc,
                           input logic [DataW-1:0] code, input logic [DataW-1:0] clock);
    apb_write(REG_RELOAD, reload);
    apb_write(REG_PRESC, presc);
    apb_write(REG_CODE, code);
    apb_write(REG_CLOCK, clock);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // capture values lean toward zero, all ones and small counts
  function automatic logic [CapW-1:0] pick_cap();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CapW'($urandom_range(0, 15));
      default: return CapW'($urandom_range(0, 65535));
    endcase
  endfunction

  // start edge, some overflow ticks, closing edge
  task automatic random_measure();
    int unsigned ticks;
    case ($urandom_range(0, 9))
      0:       ticks = 0;
      1, 2:    ticks = $urandom_range(4, 24);
      3:       ticks = $urandom_range(25, 40);
      default: ticks = $urandom_range(0, 3);
    endcase
    push_event(CmdEdge, CapW'($urandom_range(0, 65535)));
    repeat (ticks) push_event(CmdTick, CapW'($urandom_range(0, 65535)));
    push_event(CmdEdge, pick_cap());
  endtask

  initial begin
    int unsigned p;
    int unsigned phase_goal;
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CmdTick;
    in_ch.capture_value <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle tick, zero period, plain and multi-overflow periods
    push_event(CmdTick, 16'hFFFF);
    push_event(CmdEdge, 16'h0000);
    push_event(CmdEdge, 16'h0000);
    push_event(CmdEdge, 16'hFFFF);
    push_event(CmdEdge, 16'hFFFF);
    push_event(CmdEdge, 16'h5555);
    push_event(CmdTick, 16'h0000);
    push_event(CmdTick, 16'hAAAA);
    push_event(CmdEdge, 16'h0001);
    push_event(CmdEdge, 16'h8000);
    push_event(CmdTick, 16'h7FFF);
    push_event(CmdEdge, 16'h7FFF);

    for (p = 0; p < Phases; p++) begin
      drain();
      case (p)
        0:       set_meter(32'h0, 32'h0, 32'h3, 32'h0FFF_FFFF);
        1:       set_meter(32'hFFFF, 32'hFFFF, 32'h0, 32'h1);
        2:       set_meter($urandom, $urandom_range(0, 15), $urandom, 32'h0);
        default: set_meter($urandom, $urandom_range(0, 15), $urandom, $urandom);
      endcase
      if (p == 0) begin
        // fastest count rate: largest frequency, short periods, zero period
        push_event(CmdEdge, 16'hFFFF);
        push_event(CmdEdge, 16'h0001);
        push_event(CmdEdge, 16'h0000);
        push_event(CmdTick, 16'h0000);
        push_event(CmdTick, 16'hFFFF);
        push_event(CmdTick, 16'h1234);
        push_event(CmdEdge, 16'h0000);
        push_event(CmdEdge, 16'h0000);
        push_event(CmdEdge, 16'h0000);
        hold_off_req = 1'b1;
      end
      phase_goal = items_sent + RandomItems / Phases;
      while (items_sent < phase_goal) begin
        if ($urandom_range(0, 4) != 0)
          random_measure();
        else
          push_event(1'($urandom_range(0, 1)), CapW'($urandom_range(0, 65535)));
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("input_capture_frequency_meter_top: match");
    else
      $display("input_capture_frequency_meter_top: mismatch");
    $finish;
  end

endmodule
